/* hdl/dqms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqms_pkg
// Shared types, constants and ring index helpers for the double-ended queue
// with membership search.
// ----------------------------------------------------------------------------
package dqms_pkg;

   // sizing
   localparam int DEPTH      = 64;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int OP_BITS    = 3;
   localparam int STAT_BITS  = 2;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_SEARCH     = 3'd4;

   // status codes
   localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd2;

   // memory access request from the sequencer
   typedef struct packed {
      logic                  wr_en;
      logic [IDX_BITS-1:0]   wr_addr;
      logic [VALUE_BITS-1:0] wr_data;
      logic                  rd_en;
      logic [IDX_BITS-1:0]   rd_addr;
   } mem_req_type;

   // one result transaction
   typedef struct packed {
      logic [VALUE_BITS-1:0] popped_value;
      logic                  found;
      logic [STAT_BITS-1:0]  status;
      logic [CNT_BITS-1:0]   entry_count;
   } result_type;

   // ring position a + b, both below DEPTH
   function automatic logic [IDX_BITS-1:0] ring_add(input logic [IDX_BITS-1:0] a,
                                                     input logic [IDX_BITS-1:0] b);
      logic [IDX_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (IDX_BITS + 1)'(DEPTH)) begin
         sum = sum - (IDX_BITS + 1)'(DEPTH);
      end
      return sum[IDX_BITS-1:0];
   endfunction

   // ring position one before a
   function automatic logic [IDX_BITS-1:0] ring_dec(input logic [IDX_BITS-1:0] a);
      logic [IDX_BITS-1:0] res;
      if (a == '0) begin
         res = IDX_BITS'(DEPTH - 1);
      end else begin
         res = a - IDX_BITS'(1);
      end
      return res;
   endfunction

endpackage

/* hdl/dqms_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqms_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module dqms_ram #(
   parameter int DATA_BITS = 32,
   parameter int WORDS     = 64,
   parameter int ADDR_BITS = $clog2(WORDS)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [WORDS];
   logic [DATA_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/dqms_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqms_seq
// Sequencer: holds the front index and the entry count, issues ring buffer
// reads and writes, walks held entries for a search and builds the result.
// ----------------------------------------------------------------------------
module dqms_seq import dqms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_BITS-1:0]    req_op,
   input  logic [VALUE_BITS-1:0] req_item_value,
   input  logic                  out_free,
   input  logic [VALUE_BITS-1:0] rd_data,
   output mem_req_type           mem_req,
   output logic                  res_valid,
   output result_type            res
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   front_ff, front_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [OP_BITS-1:0]    op_ff, op_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [IDX_BITS-1:0]   scan_ff, scan_in;

   logic                  is_full;
   logic                  is_empty;
   logic                  hit;
   logic                  last_entry;
   logic [IDX_BITS-1:0]   rd_offset;
   logic [IDX_BITS-1:0]   back_offset;

   assign is_full     = (count_ff == CNT_BITS'(DEPTH));
   assign is_empty    = (count_ff == '0);
   assign hit         = (rd_data == value_ff);
   assign back_offset = IDX_BITS'(count_ff - CNT_BITS'(1));
   assign last_entry  = (CNT_BITS'(scan_ff) == count_ff - CNT_BITS'(1));
   assign req_ready   = (state_ff == S_IDLE);

   // read address: the entry that the next step looks at
   always_comb begin
      case (state_ff)
         S_IDLE:  rd_offset = (req_op == OP_POP_BACK) ? back_offset : '0;
         S_EXEC:  rd_offset = IDX_BITS'(1);
         S_SCAN:  rd_offset = scan_ff + IDX_BITS'(1);
         default: rd_offset = '0;
      endcase
   end

   // next state, memory requests and result
   always_comb begin
      state_in         = state_ff;
      front_in         = front_ff;
      count_in         = count_ff;
      op_in            = op_ff;
      value_in         = value_ff;
      scan_in          = scan_ff;
      mem_req.wr_en    = 1'b0;
      mem_req.wr_addr  = ring_add(front_ff, count_ff[IDX_BITS-1:0]);
      mem_req.wr_data  = value_ff;
      mem_req.rd_en    = (state_ff == S_IDLE) || out_free;
      mem_req.rd_addr  = ring_add(front_ff, rd_offset);
      res_valid        = 1'b0;
      res.popped_value = '0;
      res.found        = 1'b0;
      res.status       = STAT_OK;
      res.entry_count  = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               value_in = req_item_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
               case (op_ff)
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        res.status = STAT_FULL;
                     end else begin
                        front_in        = ring_dec(front_ff);
                        count_in        = count_ff + CNT_BITS'(1);
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ring_dec(front_ff);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        res.status = STAT_FULL;
                     end else begin
                        count_in      = count_ff + CNT_BITS'(1);
                        mem_req.wr_en = 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        res.status = STAT_EMPTY;
                     end else begin
                        res.popped_value = rd_data;
                        front_in         = ring_add(front_ff, IDX_BITS'(1));
                        count_in         = count_ff - CNT_BITS'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        res.status = STAT_EMPTY;
                     end else begin
                        res.popped_value = rd_data;
                        count_in         = count_ff - CNT_BITS'(1);
                     end
                  end
                  OP_SEARCH: begin
                     // first held entry was read while the transaction was taken
                     if (!is_empty && hit) begin
                        res.found = 1'b1;
                     end else if (!is_empty && count_ff != CNT_BITS'(1)) begin
                        res_valid = 1'b0;
                        scan_in   = IDX_BITS'(1);
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
               res.entry_count = count_in;
            end
         end
         S_SCAN: begin
            // one held entry compared per cycle while the output register has space
            if (out_free) begin
               if (hit || last_entry) begin
                  res_valid = 1'b1;
                  res.found = hit;
                  state_in  = S_IDLE;
               end else begin
                  scan_in = scan_ff + IDX_BITS'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
      op_ff    <= op_in;
      value_ff <= value_in;
      scan_ff  <= scan_in;
   end

`ifndef SYNTHESIS
   // entry count stays within the ring
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("entry count above depth");

   // a result is only produced when the output register can take it
   a_res_space: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("result produced while output register busy");

   // full status only when the ring is full, empty status only when empty
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status == STAT_FULL |-> is_full && res.entry_count == count_ff)
      else $error("full status with free space");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status == STAT_EMPTY |-> is_empty)
      else $error("empty status with held entries");

   // count changes only on a completed transaction
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !res_valid |=> $stable(count_ff))
      else $error("entry count changed without a result");
`endif

endmodule

/* hdl/deque_with_membership_search_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_membership_search_top
// Bounded double-ended queue kept as a ring buffer in one RAM, with push and
// pop at both ends and a membership search over held entries.
// ----------------------------------------------------------------------------
//  channel  ports                                   direction  per transaction
//  req      req_valid/ready, op, item_value         in         one operation
//  rsp      rsp_valid/ready, popped_value, found,   out        one result
//           status, entry_count
//
//  push, pop, no-op: accept, then ring RAM access.
//  search: accept, then held entries compared up to the first hit, one per
//  cycle through the single RAM read port while the output register has space.
//  reset: synchronous, clears front index and entry count; RAM is not cleared.
//  a new transaction is taken while a result waits in the output register;
//  the sequencer stalls only when that register is still full.
// ----------------------------------------------------------------------------
module deque_with_membership_search_top import dqms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_BITS-1:0]    req_op,
   input  logic [VALUE_BITS-1:0] req_item_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS-1:0] rsp_popped_value,
   output logic                  rsp_found,
   output logic [STAT_BITS-1:0]  rsp_status,
   output logic [CNT_BITS-1:0]   rsp_entry_count
);

   mem_req_type           mem_req;
   logic [VALUE_BITS-1:0] rd_data;
   logic                  res_valid;
   result_type            res;
   logic                  out_free;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;

   // sequencer
   dqms_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_item_value (req_item_value),
      .out_free       (out_free),
      .rd_data        (rd_data),
      .mem_req        (mem_req),
      .res_valid      (res_valid),
      .res            (res)
   );

   // ring buffer storage
   dqms_ram #(
      .DATA_BITS (VALUE_BITS),
      .WORDS     (DEPTH),
      .ADDR_BITS (IDX_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_ff.popped_value;
   assign rsp_found        = rsp_ff.found;
   assign rsp_status       = rsp_ff.status;
   assign rsp_entry_count  = rsp_ff.entry_count;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended queue with membership search.
// A queue of operations is built up front: a short directed list of corner
// cases, then random phases of mixed traffic, fills to full, drains to empty
// and search bursts. A clocked driver presents them on the req channel with
// random gaps. A clocked monitor predicts each accepted transaction and checks
// every rsp transaction against the oldest prediction. The receiver stalls at
// random, once for a long stretch; the sender pauses now and then until all
// results are back.
// ----------------------------------------------------------------------------
module tb_top;
   import dqms_pkg::*;

   // op codes the block treats as no operation
   localparam logic [OP_BITS-1:0] OP_NOP_A = 3'd5;
   localparam logic [OP_BITS-1:0] OP_NOP_B = 3'd6;
   localparam logic [OP_BITS-1:0] OP_NOP_C = 3'd7;

   localparam int RANDOM_ITEMS  = 410;
   localparam int MAX_GAP       = 14;
   localparam int LONG_HOLD_AT  = 200;
   localparam int LONG_HOLD_LEN = 400;
   localparam int SETTLE_CYCLES = 2 * DEPTH + 20;

   typedef struct {
      logic [OP_BITS-1:0]    op;
      logic [VALUE_BITS-1:0] value;
      int                    gap;
      bit                    wait_idle;
   } deque_request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OP_BITS-1:0]    req_op = '0;
   logic [VALUE_BITS-1:0] req_item_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [VALUE_BITS-1:0] rsp_popped_value;
   logic                  rsp_found;
   logic [STAT_BITS-1:0]  rsp_status;
   logic [CNT_BITS-1:0]   rsp_entry_count;

   deque_request_type queued_requests[$];
   result_type        awaited_results[$];
   logic [VALUE_BITS-1:0] value_pool[8];

   // shadow of the ring buffer
   logic [VALUE_BITS-1:0] shadow_ring[DEPTH];
   int shadow_front = 0;
   int shadow_count = 0;

   int  total_requests = 0;
   int  gen_occupancy  = 0;
   int  accepted_count = 0;
   int  results_seen   = 0;
   int  mismatches     = 0;
   int  full_refusals  = 0;
   int  empty_refusals = 0;
   int  search_hits    = 0;
   bit  req_taken      = 1'b0;
   bit  rsp_taken      = 1'b0;

   deque_with_membership_search_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_item_value   (req_item_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_popped_value (rsp_popped_value),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count)
   );

   // clock
   always #10 clock = ~clock;

   // reset
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // apply one operation to the shadow deque and return its result
   function automatic result_type predict_deque(input logic [OP_BITS-1:0] op,
                                                input logic [VALUE_BITS-1:0] value);
      result_type res;
      res = '0;
      case (op)
         OP_PUSH_FRONT: begin
            if (shadow_count == DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
               shadow_ring[shadow_front] = value;
               shadow_count++;
            end
         end
         OP_PUSH_BACK: begin
            if (shadow_count == DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               shadow_ring[(shadow_front + shadow_count) % DEPTH] = value;
               shadow_count++;
            end
         end
         OP_POP_FRONT: begin
            if (shadow_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.popped_value = shadow_ring[shadow_front];
               shadow_front = (shadow_front + 1) % DEPTH;
               shadow_count--;
            end
         end
         OP_POP_BACK: begin
            if (shadow_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.popped_value = shadow_ring[(shadow_front + shadow_count - 1) % DEPTH];
               shadow_count--;
            end
         end
         OP_SEARCH: begin
            for (int k = 0; k < shadow_count; k++) begin
               if (shadow_ring[(shadow_front + k) % DEPTH] == value) begin
                  res.found = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      res.entry_count = CNT_BITS'(shadow_count);
      return res;
   endfunction

   // queue an operation and track how full the deque will be
   task automatic add_request(input logic [OP_BITS-1:0] op, input logic [VALUE_BITS-1:0] value,
                              input int gap, input bit wait_idle);
      deque_request_type item;
      item.op        = op;
      item.value     = value;
      item.gap       = gap;
      item.wait_idle = wait_idle;
      queued_requests.push_back(item);
      total_requests++;
      if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_occupancy < DEPTH) begin
         gen_occupancy++;
      end else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && gen_occupancy > 0) begin
         gen_occupancy--;
      end
   endtask

   // pool values make searches hit now and then
   function automatic logic [VALUE_BITS-1:0] pick_value();
      logic [VALUE_BITS-1:0] v;
      if ($urandom_range(0, 2) == 0) begin
         v = value_pool[$urandom_range(0, 7)];
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   function automatic logic [OP_BITS-1:0] pick_push();
      return ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
   endfunction

   function automatic logic [OP_BITS-1:0] pick_pop();
      return ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
   endfunction

   // stimulus: directed corner cases, then random phases
   initial begin : build_stimulus
      int random_ops;
      int phase;
      int kind;
      int span;
      int r;
      bit calm;
      bit pause;
      logic [OP_BITS-1:0] op;
      random_ops = 0;
      phase = 0;
      value_pool[0] = '0;
      value_pool[1] = '1;
      for (int p = 2; p < 8; p++) begin
         value_pool[p] = $urandom;
      end

      // empty deque, extreme values, wrap at the front, no-op codes
      add_request(OP_POP_FRONT,  $urandom,      $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_POP_BACK,   $urandom,      $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_SEARCH,     32'h0,         $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_PUSH_FRONT, 32'h0,         0,                          1'b0);
      add_request(OP_PUSH_BACK,  32'hFFFF_FFFF, 0,                          1'b0);
      add_request(OP_PUSH_FRONT, 32'h8000_0000, $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_PUSH_BACK,  32'h0000_0001, $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_SEARCH,     32'h0,         0,                          1'b0);
      add_request(OP_SEARCH,     32'hFFFF_FFFF, $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_SEARCH,     32'h7FFF_FFFF, $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_NOP_A,      $urandom,      $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_NOP_B,      32'hFFFF_FFFF, 0,                          1'b0);
      add_request(OP_NOP_C,      $urandom,      $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_POP_BACK,   $urandom,      $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_POP_FRONT,  $urandom,      0,                          1'b0);
      add_request(OP_POP_FRONT,  $urandom,      $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_POP_BACK,   $urandom,      $urandom_range(0, MAX_GAP), 1'b0);
      add_request(OP_POP_BACK,   $urandom,      0,                          1'b0);
      add_request(OP_SEARCH,     32'hFFFF_FFFF, $urandom_range(0, MAX_GAP), 1'b0);

      // random phases: mixed traffic, fill to full, drain to empty, searches
      while (random_ops < RANDOM_ITEMS) begin
         kind  = $urandom_range(0, 3);
         calm  = ($urandom_range(0, 3) == 0);
         pause = (phase == 2) || ($urandom_range(0, 4) == 0);
         case (kind)
            0:       span = $urandom_range(20, 40);
            1:       span = DEPTH - gen_occupancy + $urandom_range(1, 3);
            2:       span = gen_occupancy + $urandom_range(1, 3);
            default: span = $urandom_range(10, 20);
         endcase
         for (int n = 0; n < span; n++) begin
            r = $urandom_range(0, 99);
            case (kind)
               0: begin
                  if (r < 35) begin
                     op = pick_push();
                  end else if (r < 65) begin
                     op = pick_pop();
                  end else if (r < 94) begin
                     op = OP_SEARCH;
                  end else if (r < 96) begin
                     op = OP_NOP_A;
                  end else if (r < 98) begin
                     op = OP_NOP_B;
                  end else begin
                     op = OP_NOP_C;
                  end
               end
               1:       op = pick_push();
               2:       op = pick_pop();
               default: op = (r < 80) ? OP_SEARCH : pick_push();
            endcase
            add_request(op, pick_value(), calm ? 0 : $urandom_range(0, MAX_GAP),
                        pause && n == 0);
            if (op <= OP_SEARCH) begin
               random_ops++;
            end
         end
         phase++;
      end
   end

   // request driver
   always @(negedge clock) begin : drive_requests
      int gap_left;
      bit gap_loaded;
      bit next_valid;
      deque_request_type cur;
      if (!reset && (req_taken || !req_valid)) begin
         req_taken  = 1'b0;
         next_valid = 1'b0;
         if (queued_requests.size() > 0) begin
            if (!gap_loaded) begin
               gap_left   = queued_requests[0].gap;
               gap_loaded = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
            end else if (!queued_requests[0].wait_idle || awaited_results.size() == 0) begin
               cur        = queued_requests.pop_front();
               gap_loaded = 1'b0;
               next_valid = 1'b1;
               req_op         <= cur.op;
               req_item_value <= cur.value;
            end
         end
         req_valid <= next_valid;
      end
   end

   // result receiver, with one long hold-off
   always @(negedge clock) begin : drive_ready
      int hold_left;
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if (results_seen == LONG_HOLD_AT) begin
               hold_left = LONG_HOLD_LEN;
            end else if ((results_seen / 40) % 3 == 0) begin
               hold_left = 0;
            end else begin
               hold_left = $urandom_range(0, MAX_GAP);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // monitor: predict accepted requests, check accepted results
   always @(posedge clock) begin : watch_channels
      result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            awaited_results.push_back(predict_deque(req_op, req_item_value));
            accepted_count++;
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            rsp_taken = 1'b1;
            if (awaited_results.size() == 0) begin
               $error("result transaction with no expectation pending");
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               check_field("popped_value", 64'(want.popped_value), 64'(rsp_popped_value));
               check_field("found", 64'(want.found), 64'(rsp_found));
               check_field("status", 64'(want.status), 64'(rsp_status));
               check_field("entry_count", 64'(want.entry_count), 64'(rsp_entry_count));
               if (want.status == STAT_FULL) full_refusals++;
               if (want.status == STAT_EMPTY) empty_refusals++;
               if (want.found) search_hits++;
            end
         end
      end
   end

   // end of run
   initial begin : finish_run
      @(negedge reset);
      while (!(accepted_count == total_requests && awaited_results.size() == 0)) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d transactions with fills past full, drains past empty and wrap",
               results_seen);
      $display("refused pushes on full: %0d, pops on empty: %0d, search hits: %0d",
               full_refusals, empty_refusals, search_hits);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
